### src/mtt_pkg.sv
// Package for the microsecond timeout timer core.
// Holds field widths, kind codes, range limits and the sequencer state type.
// No dependencies.
package mtt_pkg;

    localparam int unsigned KIND_W     = 2;
    localparam int unsigned DELAY_W    = 25;
    localparam int unsigned TICK_W     = 8;
    localparam int unsigned TOTAL_W    = DELAY_W + TICK_W;
    localparam int unsigned PRESCALE_W = 15;
    localparam int unsigned RELOAD_W   = 16;
    localparam int unsigned DIVISOR_W  = PRESCALE_W + 1;
    localparam int unsigned DIV_STEPS  = TOTAL_W;
    localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

    localparam logic [DELAY_W-1:0]    DELAY_MAX    = 25'd29826161;
    localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = '1;
    localparam logic [RELOAD_W-1:0]   RELOAD_MAX   = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### src/microsecond_timeout_timer_core.sv
// Microsecond timeout timer core: prescaled down counter with start-time
// reload computation on a single restoring divider.
// Depends on mtt_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_stall  | kind, delay_us
//  out     | output    | out_valid / out_stall| accepted, timeout, running,
//          |           |                      | prescale, reload
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (one_shot)
//
// Ticks, stops, refused starts and unknown kinds are answered from the idle state.
// A start with nonzero delay goes through accept, multiply, prescale,
// 33 divider steps at one quotient bit per cycle, and commit.
// rst_n clears the timer state, one_shot and out_valid at once.
// in_stall is high while a start is computed, and while a result waits under
// out_stall; a request may be taken in the cycle its predecessor is taken.
module microsecond_timeout_timer_core #(
    parameter int unsigned TICKS_PER_US = 72
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mtt_pkg::KIND_W-1:0]         kind,
    input  logic [mtt_pkg::DELAY_W-1:0]        delay_us,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               accepted,
    output logic                               timeout,
    output logic                               running,
    output logic [mtt_pkg::PRESCALE_W-1:0]     prescale,
    output logic [mtt_pkg::RELOAD_W-1:0]       reload,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data
);

    localparam logic [mtt_pkg::TICK_W-1:0] TICKS = mtt_pkg::TICK_W'(TICKS_PER_US);

    mtt_pkg::state_t state_reg, state_next;

    logic                              one_shot_reg;
    logic                              enabled_reg, enabled_next;
    logic [mtt_pkg::PRESCALE_W-1:0]    prescale_value_reg, prescale_value_next;
    logic [mtt_pkg::PRESCALE_W-1:0]    prescale_count_reg, prescale_count_next;
    logic [mtt_pkg::RELOAD_W-1:0]      reload_value_reg, reload_value_next;
    logic [mtt_pkg::RELOAD_W-1:0]      down_count_reg, down_count_next;
    logic [mtt_pkg::STEP_W-1:0]        step_reg, step_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              accepted_reg, accepted_next;
    logic                              timeout_reg, timeout_next;
    logic                              running_reg, running_next;
    logic [mtt_pkg::PRESCALE_W-1:0]    prescale_reg, prescale_next;
    logic [mtt_pkg::RELOAD_W-1:0]      reload_reg, reload_next;

    // divider datapath
    logic [mtt_pkg::DELAY_W-1:0]       delay_reg, delay_next;
    logic [mtt_pkg::TOTAL_W-1:0]       total_reg, total_next;
    logic [mtt_pkg::PRESCALE_W-1:0]    pre_reg, pre_next;
    logic [mtt_pkg::DIVISOR_W-1:0]     divisor_reg, divisor_next;
    logic [mtt_pkg::TOTAL_W-1:0]       quot_reg, quot_next;
    logic [mtt_pkg::DIVISOR_W-1:0]     rem_reg, rem_next;

    logic                              in_accept;
    logic                              out_free;
    logic [mtt_pkg::TOTAL_W-1:0]       total_m1;
    logic [mtt_pkg::TOTAL_W-16-1:0]    pre_raw;
    logic [mtt_pkg::DIVISOR_W:0]       rem_shift;
    logic                              rem_ge;
    logic [mtt_pkg::TOTAL_W-1:0]       quot_m1;
    logic [mtt_pkg::RELOAD_W-1:0]      reload_calc;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != mtt_pkg::ST_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;

    assign total_m1  = total_reg - mtt_pkg::TOTAL_W'(1);
    assign pre_raw   = total_m1[mtt_pkg::TOTAL_W-1:16];
    assign rem_shift = {rem_reg, quot_reg[mtt_pkg::TOTAL_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    assign quot_m1   = quot_reg - mtt_pkg::TOTAL_W'(1);

    always_comb
    begin
        if (quot_reg == '0)
            reload_calc = '0;
        else if (quot_m1[mtt_pkg::TOTAL_W-1:mtt_pkg::RELOAD_W] != '0)
            reload_calc = mtt_pkg::RELOAD_MAX;
        else
            reload_calc = quot_m1[mtt_pkg::RELOAD_W-1:0];
    end

    always_comb
    begin
        state_next          = state_reg;
        enabled_next        = enabled_reg;
        prescale_value_next = prescale_value_reg;
        prescale_count_next = prescale_count_reg;
        reload_value_next   = reload_value_reg;
        down_count_next     = down_count_reg;
        step_next           = step_reg;
        delay_next          = delay_reg;
        total_next          = total_reg;
        pre_next            = pre_reg;
        divisor_next        = divisor_reg;
        quot_next           = quot_reg;
        rem_next            = rem_reg;
        accepted_next       = 1'b0;
        timeout_next        = 1'b0;
        out_valid_next      = out_valid_reg && out_stall;
        case (state_reg)
            mtt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (kind == mtt_pkg::KIND_START && delay_us != '0)
                    begin
                        delay_next = (delay_us > mtt_pkg::DELAY_MAX) ?
                                     mtt_pkg::DELAY_MAX : delay_us;
                        state_next = mtt_pkg::ST_MUL;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (kind == mtt_pkg::KIND_TICK && enabled_reg)
                        begin
                            if (prescale_count_reg == prescale_value_reg)
                            begin
                                prescale_count_next = '0;
                                if (down_count_reg == '0)
                                begin
                                    timeout_next    = 1'b1;
                                    down_count_next = reload_value_reg;
                                    if (one_shot_reg)
                                        enabled_next = 1'b0;
                                end
                                else
                                    down_count_next = down_count_reg
                                                      - mtt_pkg::RELOAD_W'(1);
                            end
                            else
                                prescale_count_next = prescale_count_reg
                                                      + mtt_pkg::PRESCALE_W'(1);
                        end
                        else if (kind == mtt_pkg::KIND_STOP)
                            enabled_next = 1'b0;
                    end
                end
            end
            mtt_pkg::ST_MUL:
            begin
                total_next = mtt_pkg::TOTAL_W'(TICKS) * mtt_pkg::TOTAL_W'(delay_reg);
                state_next = mtt_pkg::ST_SCALE;
            end
            mtt_pkg::ST_SCALE:
            begin
                // saturate when any bit above the prescale width is set
                pre_next     = (pre_raw[mtt_pkg::TOTAL_W-16-1:mtt_pkg::PRESCALE_W] != '0) ?
                               mtt_pkg::PRESCALE_MAX : pre_raw[mtt_pkg::PRESCALE_W-1:0];
                divisor_next = mtt_pkg::DIVISOR_W'(pre_next) + mtt_pkg::DIVISOR_W'(1);
                quot_next    = total_reg;
                rem_next     = '0;
                step_next    = '0;
                state_next   = mtt_pkg::ST_DIV;
            end
            mtt_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next  = rem_ge ? mtt_pkg::DIVISOR_W'(rem_shift - {1'b0, divisor_reg})
                                   : rem_shift[mtt_pkg::DIVISOR_W-1:0];
                quot_next = {quot_reg[mtt_pkg::TOTAL_W-2:0], rem_ge};
                step_next = step_reg + mtt_pkg::STEP_W'(1);
                if (step_reg == mtt_pkg::STEP_W'(mtt_pkg::DIV_STEPS - 1))
                    state_next = mtt_pkg::ST_DONE;
            end
            mtt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    prescale_value_next = pre_reg;
                    reload_value_next   = reload_calc;
                    prescale_count_next = '0;
                    down_count_next     = reload_calc;
                    enabled_next        = 1'b1;
                    accepted_next       = 1'b1;
                    out_valid_next      = 1'b1;
                    state_next          = mtt_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mtt_pkg::ST_IDLE;
        endcase
        running_next  = enabled_next;
        prescale_next = prescale_value_next;
        reload_next   = reload_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= mtt_pkg::ST_IDLE;
            one_shot_reg       <= 1'b0;
            enabled_reg        <= 1'b0;
            prescale_value_reg <= '0;
            prescale_count_reg <= '0;
            reload_value_reg   <= mtt_pkg::RELOAD_MAX;
            down_count_reg     <= '0;
            step_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            if (cfg_valid && cfg_ready)
                one_shot_reg   <= cfg_data;
            enabled_reg        <= enabled_next;
            prescale_value_reg <= prescale_value_next;
            prescale_count_reg <= prescale_count_next;
            reload_value_reg   <= reload_value_next;
            down_count_reg     <= down_count_next;
            step_reg           <= step_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        delay_reg   <= delay_next;
        total_reg   <= total_next;
        pre_reg     <= pre_next;
        divisor_reg <= divisor_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        if (out_free)
        begin
            accepted_reg <= accepted_next;
            timeout_reg  <= timeout_next;
            running_reg  <= running_next;
            prescale_reg <= prescale_next;
            reload_reg   <= reload_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign timeout   = timeout_reg;
    assign running   = running_reg;
    assign prescale  = prescale_reg;
    assign reload    = reload_reg;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> state_reg == mtt_pkg::ST_IDLE)
        else $error("request taken while sequencer busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prescale_count_reg <= prescale_value_reg)
        else $error("prescaler count beyond prescale value");

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && accepted_reg |-> running_reg)
        else $error("accepted start reported without running timer");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mtt_pkg::ST_DIV && step_reg == mtt_pkg::STEP_W'(mtt_pkg::DIV_STEPS - 1)
        |=> state_reg == mtt_pkg::ST_DONE)
        else $error("divider did not finish after last step");
`endif

endmodule

### test/microsecond_timeout_timer_core_test.sv
// Testbench for microsecond_timeout_timer_core: directed and random tick/start/stop/unknown-kind
// requests, with a scoreboard that predicts every result. Depends on mtt_pkg and the core.
`timescale 1ns / 100ps

module microsecond_timeout_timer_core_test;

    localparam int unsigned TICKS_PER_US = 72;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned PHASE_ITEMS  = 440;
    localparam int unsigned TAIL_CYCLES  = 45;   // covers the start path
    localparam logic [mtt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic                           accepted;
        logic                           fired;
        logic                           running;
        logic [mtt_pkg::PRESCALE_W-1:0] prescale;
        logic [mtt_pkg::RELOAD_W-1:0]   reload;
    } timer_result_t;

    class timer_scoreboard;
        bit                             one_shot;
        bit                             run_q;
        logic [mtt_pkg::PRESCALE_W-1:0] presc_val;
        logic [mtt_pkg::PRESCALE_W-1:0] presc_cnt;
        logic [mtt_pkg::RELOAD_W-1:0]   reload_val;
        logic [mtt_pkg::RELOAD_W-1:0]   down_cnt;
        timer_result_t                  expected_q[$];
        int                             errors;

        function new();
            errors     = 0;
            one_shot   = 0;
            run_q      = 0;
            presc_val  = '0;
            presc_cnt  = '0;
            reload_val = mtt_pkg::RELOAD_MAX;
            down_cnt   = '0;
        endfunction

        function void set_one_shot(bit v);
            one_shot = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // Advance the timer model by one accepted request and queue its result.
        function void note_request(logic [mtt_pkg::KIND_W-1:0] k,
                                   logic [mtt_pkg::DELAY_W-1:0] delay);
            timer_result_t               res;
            logic [mtt_pkg::DELAY_W-1:0] d;
            longint unsigned             total;
            longint unsigned             p;
            longint unsigned             r;
            res.accepted = 0;
            res.fired    = 0;
            case (k)
                mtt_pkg::KIND_TICK:
                    if (run_q)
                    begin
                        if (presc_cnt == presc_val)
                        begin
                            presc_cnt = '0;
                            if (down_cnt == 0)
                            begin
                                res.fired = 1;
                                down_cnt  = reload_val;
                                if (one_shot)
                                    run_q = 0;
                            end
                            else
                                down_cnt = down_cnt - 1'b1;
                        end
                        else
                            presc_cnt = presc_cnt + 1'b1;
                    end
                mtt_pkg::KIND_START:
                    if (delay != 0)
                    begin
                        d     = (delay > mtt_pkg::DELAY_MAX) ? mtt_pkg::DELAY_MAX : delay;
                        total = d;
                        total = total * TICKS_PER_US;
                        p     = (total - 1) >> 16;
                        if (p > mtt_pkg::PRESCALE_MAX)
                            p = mtt_pkg::PRESCALE_MAX;
                        r = total / (p + 1);
                        r = (r == 0) ? 0 : r - 1;
                        if (r > mtt_pkg::RELOAD_MAX)
                            r = mtt_pkg::RELOAD_MAX;
                        presc_val    = p[mtt_pkg::PRESCALE_W-1:0];
                        reload_val   = r[mtt_pkg::RELOAD_W-1:0];
                        presc_cnt    = '0;
                        down_cnt     = r[mtt_pkg::RELOAD_W-1:0];
                        run_q        = 1;
                        res.accepted = 1;
                    end
                mtt_pkg::KIND_STOP:
                    run_q = 0;
                default:
                    ;
            endcase
            res.running  = run_q;
            res.prescale = presc_val;
            res.reload   = reload_val;
            expected_q.push_back(res);
        endfunction

        task check_result(logic acc, logic tmo, logic run,
                          logic [mtt_pkg::PRESCALE_W-1:0] ps,
                          logic [mtt_pkg::RELOAD_W-1:0] rl);
            timer_result_t want;
            if (expected_q.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (acc !== want.accepted)
                report($sformatf("accepted %0b, want %0b", acc, want.accepted));
            if (tmo !== want.fired)
                report($sformatf("timeout %0b, want %0b", tmo, want.fired));
            if (run !== want.running)
                report($sformatf("running %0b, want %0b", run, want.running));
            if (ps !== want.prescale)
                report($sformatf("prescale %0d, want %0d", ps, want.prescale));
            if (rl !== want.reload)
                report($sformatf("reload %0d, want %0d", rl, want.reload));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [mtt_pkg::KIND_W-1:0]     kind;
    logic [mtt_pkg::DELAY_W-1:0]    delay_us;
    logic                           out_valid;
    logic                           out_stall;
    logic                           accepted;
    logic                           timeout;
    logic                           running;
    logic [mtt_pkg::PRESCALE_W-1:0] prescale;
    logic [mtt_pkg::RELOAD_W-1:0]   reload;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic                           cfg_data;

    timer_scoreboard sb;
    bit              no_idle;
    int unsigned     items_sent;
    int unsigned     cycle_count;

    microsecond_timeout_timer_core #(
        .TICKS_PER_US(TICKS_PER_US)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .delay_us (delay_us),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .accepted (accepted),
        .timeout  (timeout),
        .running  (running),
        .prescale (prescale),
        .reload   (reload),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("microsecond_timeout_timer_core test failed");
            $finish;
        end
    end

    // Result side: random back-pressure, sampled results checked at the rising edge.
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            out_stall = !no_idle && ($urandom_range(99) < 9);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(accepted, timeout, running, prescale, reload);
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with in_valid still high.
    task automatic send_request(input logic [mtt_pkg::KIND_W-1:0] k,
                                input logic [mtt_pkg::DELAY_W-1:0] d);
        int gap;
        if (!no_idle && $urandom_range(99) < 9)
        begin
            gap      = $urandom_range(1, 2);
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1;
        kind     = k;
        delay_us = d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(k, d);
        if (k != KIND_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_one_shot(input bit v);
        wait_drained();
        cfg_valid = 1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_one_shot(v);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // Mostly short delays so that timeouts happen within a few hundred ticks.
    function automatic logic [mtt_pkg::DELAY_W-1:0] pick_delay();
        int                          sel;
        logic [mtt_pkg::DELAY_W-1:0] d;
        sel = $urandom_range(99);
        d   = mtt_pkg::DELAY_W'($urandom);
        if (sel < 70)
            d = mtt_pkg::DELAY_W'($urandom_range(1, 3));
        else if (sel < 85)
            d = mtt_pkg::DELAY_W'($urandom_range(1, 910));
        else if (sel >= 97)
            d = '0;
        return d;
    endfunction

    task automatic run_phase(input int unsigned count);
        int unsigned                 target;
        int unsigned                 n_ticks;
        int unsigned                 sel;
        logic [mtt_pkg::DELAY_W-1:0] rnd;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_request(mtt_pkg::KIND_START, pick_delay());
                n_ticks = $urandom_range(40, 240);
                while (n_ticks > 0 && items_sent < target)
                begin
                    sel = $urandom_range(999);
                    rnd = mtt_pkg::DELAY_W'($urandom);
                    if (sel < 8)
                        send_request(mtt_pkg::KIND_STOP, rnd);
                    else if (sel < 12)
                        send_request(mtt_pkg::KIND_START, pick_delay());
                    else if (sel < 14)
                        send_request(KIND_UNUSED, rnd);
                    else
                        send_request(mtt_pkg::KIND_TICK, rnd);
                    n_ticks--;
                end
            end
            else
            begin
                rnd = mtt_pkg::DELAY_W'($urandom);
                send_request(mtt_pkg::KIND_W'($urandom_range(3)), rnd);
            end
        end
    endtask

    initial
    begin
        sb          = new();
        no_idle     = 0;
        items_sent  = 0;
        cycle_count = 0;
        rst_n       = 0;
        in_valid    = 0;
        kind        = mtt_pkg::KIND_TICK;
        delay_us    = '0;
        cfg_valid   = 0;
        cfg_data    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        write_one_shot(0);

        // directed: idle timer, refused start, range edges, restarts
        send_request(mtt_pkg::KIND_TICK, '0);
        send_request(mtt_pkg::KIND_START, '0);
        send_request(mtt_pkg::KIND_STOP, '0);
        send_request(KIND_UNUSED, '1);
        send_request(mtt_pkg::KIND_START, 25'd1);
        send_request(mtt_pkg::KIND_TICK, '1);
        send_request(mtt_pkg::KIND_TICK, '0);
        send_request(mtt_pkg::KIND_START, 25'd910);
        send_request(mtt_pkg::KIND_START, 25'd911);
        send_request(mtt_pkg::KIND_START, 25'h1555555);
        send_request(mtt_pkg::KIND_START, 25'h0AAAAAA);
        send_request(mtt_pkg::KIND_START, mtt_pkg::DELAY_MAX);
        send_request(mtt_pkg::KIND_START, mtt_pkg::DELAY_MAX + 1'b1);
        send_request(mtt_pkg::KIND_START, '1);
        send_request(mtt_pkg::KIND_TICK, '0);
        send_request(mtt_pkg::KIND_TICK, '0);
        send_request(mtt_pkg::KIND_STOP, '1);
        send_request(mtt_pkg::KIND_TICK, '0);
        send_request(mtt_pkg::KIND_START, '0);
        send_request(mtt_pkg::KIND_START, 25'd2);
        send_request(mtt_pkg::KIND_TICK, '0);

        write_one_shot(1);
        run_phase(PHASE_ITEMS);
        write_one_shot(0);
        no_idle = 1;
        run_phase(PHASE_ITEMS);
        no_idle = 0;
        write_one_shot(1);
        run_phase(PHASE_ITEMS);
        write_one_shot(0);
        run_phase(PHASE_ITEMS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("microsecond_timeout_timer_core test passed");
        else
            $display("microsecond_timeout_timer_core test failed");
        $finish;
    end

endmodule
